>>> rtl/bsas_pkg.sv
// ----------------------------------------------------------------------------
// bsas_pkg
// Shared widths, constants and types of the binned spectrum agreement score.
// ----------------------------------------------------------------------------
package bsas_pkg;

  localparam int INT_BITS   = 24;                 // bin intensity width
  localparam int MZ_BITS    = 26;                 // precursor m/z, Q16.10
  localparam int SUM_BITS   = 36;                 // accumulator width
  localparam int TOT_BITS   = SUM_BITS + 1;       // sum of two accumulators
  localparam int SCORE_BITS = 17;                 // Q16 score, 1.0 included
  localparam int CNT_BITS   = $clog2(SCORE_BITS); // divider step counter

  localparam logic [MZ_BITS-1:0]    TOL_RESET = MZ_BITS'(3072);   // 3.0
  localparam logic [SCORE_BITS-1:0] Q16_ONE   = SCORE_BITS'(65536);
  localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;

  typedef enum logic [1:0] {
    ST_ACC,   // take bin pairs
    ST_PREP,  // precursor check, empty check, divider launch
    ST_DIV,   // wait on the divider
    ST_LOAD   // move the result into the output register
  } state_t;

  typedef struct packed {
    logic                start;
    logic [TOT_BITS-1:0] num;   // twice the agreeing sum
    logic [TOT_BITS-1:0] den;   // first_sum + second_sum
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [SCORE_BITS-1:0] quo;
  } div_rsp_t;

endpackage

>>> rtl/bsas_in_if.sv
// ----------------------------------------------------------------------------
// bsas_in_if
// Bin pair channel: one pair of same-position intensities per transfer.
// ----------------------------------------------------------------------------
interface bsas_in_if;
  logic                           valid;
  logic                           ready;
  logic [bsas_pkg::INT_BITS-1:0]  first_intensity;
  logic [bsas_pkg::INT_BITS-1:0]  second_intensity;
  logic [bsas_pkg::MZ_BITS-1:0]   first_precursor_mz;
  logic [bsas_pkg::MZ_BITS-1:0]   second_precursor_mz;
  logic                           last_bin;

  modport source (
    output valid, first_intensity, second_intensity,
           first_precursor_mz, second_precursor_mz, last_bin,
    input  ready
  );
  modport sink (
    input  valid, first_intensity, second_intensity,
           first_precursor_mz, second_precursor_mz, last_bin,
    output ready
  );
endinterface

>>> rtl/bsas_out_if.sv
// ----------------------------------------------------------------------------
// bsas_out_if
// Score channel: one result per comparison.
// ----------------------------------------------------------------------------
interface bsas_out_if;
  logic                            valid;
  logic                            ready;
  logic [bsas_pkg::SCORE_BITS-1:0] score;
  logic                            precursor_rejected;
  logic                            empty_input;

  modport source (
    output valid, score, precursor_rejected, empty_input,
    input  ready
  );
  modport sink (
    input  valid, score, precursor_rejected, empty_input,
    output ready
  );
endinterface

>>> rtl/bsas_cfg_if.sv
// ----------------------------------------------------------------------------
// bsas_cfg_if
// Configuration write channel for the precursor tolerance register.
// ----------------------------------------------------------------------------
interface bsas_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bsas_pkg::MZ_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/bsas_div.sv
// ----------------------------------------------------------------------------
// bsas_div
// Restoring divider, one quotient bit per cycle, Q16 result saturated at 1.0.
// ----------------------------------------------------------------------------
module bsas_div (
  input  logic               clk,
  input  logic               rst_n,
  input  bsas_pkg::div_req_t req,
  output bsas_pkg::div_rsp_t rsp
);
  import bsas_pkg::*;

  logic [TOT_BITS:0]     rem_r, rem_nxt;
  logic [TOT_BITS-1:0]   den_r;
  logic [SCORE_BITS-1:0] quo_r, quo_nxt;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  busy_r, done_r, sat_r;

  logic [TOT_BITS+1:0]   diff;
  logic                  ge;
  logic [TOT_BITS:0]     rem_sel;
  logic                  last_step;

  // shared subtract and compare
  always_comb begin
    diff      = {1'b0, rem_r} - {2'b00, den_r};
    ge        = ~diff[TOT_BITS+1];
    rem_sel   = ge ? diff[TOT_BITS:0] : rem_r;
    rem_nxt   = {rem_sel[TOT_BITS-1:0], 1'b0};
    quo_nxt   = {quo_r[SCORE_BITS-2:0], ge};
    last_step = (cnt_r == CNT_BITS'(SCORE_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_BITS'(1);
        if (last_step) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= {1'b0, req.num};
      den_r <= req.den;
      quo_r <= '0;
      sat_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      // numerator above the divisor on the leading bit: quotient exceeds 1.0
      if (cnt_r == '0 && ge && diff != '0) begin
        sat_r <= 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = sat_r ? Q16_ONE : quo_r;

endmodule

>>> rtl/binned_spectrum_agreement_score.sv
// ----------------------------------------------------------------------------
// binned_spectrum_agreement_score
// Agreement score of two binned spectra, streamed one bin pair per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one pair of same-position bin intensities per transfer;
//   the transfer with last_bin set closes a comparison and also carries the
//   two precursor m/z values. out_ch returns one result per comparison:
//   a Q16 score with rejection and empty flags. cfg_ch writes the precursor
//   tolerance (Q16.10) and is always ready; write it only while idle.
// Sequence:
//   Bin pairs that are not last are taken back to back. A last bin goes
//   through the precursor and empty checks (ST_PREP), the divider's shared
//   subtract-and-compare unit (one quotient bit a cycle) and hand-off (ST_LOAD)
//   before out_ch.valid rises; a rejected or empty one skips the divider.
//   in_ch.ready is low from the last bin until the result is registered.
// Reset:
//   rst_n clears the sums, the sequencer and out_ch.valid, and sets the
//   tolerance to 3.0.
// Back-pressure:
//   The result waits in the output register while out_ch.ready is low; the
//   next comparison streams in meanwhile and stalls only when its own result
//   is ready to load and the register is still full.
// ----------------------------------------------------------------------------
module binned_spectrum_agreement_score (
  input  logic   clk,
  input  logic   rst_n,
  bsas_in_if.sink    in_ch,
  bsas_out_if.source out_ch,
  bsas_cfg_if.sink   cfg_ch
);
  import bsas_pkg::*;

  state_t state_r, state_nxt;

  logic [SUM_BITS-1:0]   first_sum_r, second_sum_r, agree_sum_r;
  logic [MZ_BITS-1:0]    tol_r;
  logic [MZ_BITS-1:0]    mzdiff_r;
  logic [SCORE_BITS-1:0] pend_score_r;
  logic                  pend_rej_r, pend_empty_r;
  logic [SCORE_BITS-1:0] res_score_r;
  logic                  res_rej_r, res_empty_r;
  logic                  out_valid_r;

  logic                  in_ready;
  logic                  in_xfer;
  logic                  load_out;
  logic                  rej, empty;

  logic [INT_BITS-1:0]   a_i, b_i;
  logic [INT_BITS:0]     ab_sum;
  logic [INT_BITS-1:0]   half, diff;
  logic [INT_BITS-1:0]   agree;
  logic [SUM_BITS:0]     s1_add, s2_add, sa_add;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // per-bin agreement term
  always_comb begin
    a_i    = in_ch.first_intensity;
    b_i    = in_ch.second_intensity;
    ab_sum = {1'b0, a_i} + {1'b0, b_i};
    half   = ab_sum[INT_BITS:1];
    diff   = (a_i > b_i) ? (a_i - b_i) : (b_i - a_i);
    agree  = (half > diff) ? (half - diff) : '0;
    s1_add = {1'b0, first_sum_r}  + (SUM_BITS + 1)'(a_i);
    s2_add = {1'b0, second_sum_r} + (SUM_BITS + 1)'(b_i);
    sa_add = {1'b0, agree_sum_r}  + (SUM_BITS + 1)'(agree);
  end

  assign in_xfer = in_ch.valid & in_ready;
  assign rej     = (mzdiff_r > tol_r);
  assign empty   = (first_sum_r == '0) && (second_sum_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_ACC: begin
        if (in_xfer && in_ch.last_bin) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        state_nxt = (rej || empty) ? ST_LOAD : ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid_r || out_ch.ready) state_nxt = ST_ACC;
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready      = 1'b0;
    load_out      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = {agree_sum_r, 1'b0};
    div_req.den   = {1'b0, first_sum_r} + {1'b0, second_sum_r};
    case (state_r)
      ST_ACC:  in_ready      = 1'b1;
      ST_PREP: div_req.start = ~(rej | empty);
      ST_DIV:  ;
      ST_LOAD: load_out      = ~out_valid_r | out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_ACC;
      out_valid_r  <= 1'b0;
      tol_r        <= TOL_RESET;
      first_sum_r  <= '0;
      second_sum_r <= '0;
      agree_sum_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= load_out | (out_valid_r & ~out_ch.ready);
      if (cfg_ch.valid) begin
        tol_r <= cfg_ch.data;
      end
      if (in_xfer) begin
        // saturate rather than wrap
        first_sum_r  <= s1_add[SUM_BITS] ? SUM_MAX : s1_add[SUM_BITS-1:0];
        second_sum_r <= s2_add[SUM_BITS] ? SUM_MAX : s2_add[SUM_BITS-1:0];
        agree_sum_r  <= sa_add[SUM_BITS] ? SUM_MAX : sa_add[SUM_BITS-1:0];
      end else if (state_r == ST_PREP) begin
        // the divider, if launched, takes its operands now: clear for the next comparison
        first_sum_r  <= '0;
        second_sum_r <= '0;
        agree_sum_r  <= '0;
      end
    end
  end

  // payload registers; hold the pending result until the output is free
  always_ff @(posedge clk) begin
    if (in_xfer && in_ch.last_bin) begin
      mzdiff_r <= (in_ch.first_precursor_mz > in_ch.second_precursor_mz) ?
                  (in_ch.first_precursor_mz - in_ch.second_precursor_mz) :
                  (in_ch.second_precursor_mz - in_ch.first_precursor_mz);
    end
    if (state_r == ST_PREP) begin
      pend_rej_r   <= rej;
      pend_empty_r <= ~rej & empty;
      pend_score_r <= '0;
    end else if (state_r == ST_DIV && div_rsp.done) begin
      pend_score_r <= div_rsp.quo;
    end
    if (load_out) begin
      res_score_r <= pend_score_r;
      res_rej_r   <= pend_rej_r;
      res_empty_r <= pend_empty_r;
    end
  end

  bsas_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready               = in_ready;
  assign cfg_ch.ready              = 1'b1;
  assign out_ch.valid              = out_valid_r;
  assign out_ch.score              = res_score_r;
  assign out_ch.precursor_rejected = res_rej_r;
  assign out_ch.empty_input        = res_empty_r;

`ifndef SYNTH
  a_last_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last_bin) |=> (state_r == ST_PREP))
    else $error("last bin transfer did not start the score sequence");

  a_flags_zero_score: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.precursor_rejected || out_ch.empty_input))
      |-> (out_ch.score == '0))
    else $error("flagged result carries a nonzero score");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.precursor_rejected && out_ch.empty_input))
    else $error("rejected and empty flags both set");

  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.score <= Q16_ONE))
    else $error("score above 1.0");
`endif

endmodule
